// ===== design/order_statistic_sorted_set_assert.svh =====
// Assertion macros for the sorted set block.
`ifndef ORDER_STATISTIC_SORTED_SET_ASSERT_SVH
`define ORDER_STATISTIC_SORTED_SET_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define OSSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define OSSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OSSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define OSSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/osss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package osss_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_W-1:0] key_t;

  // Command codes
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_KTH    = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_PRED   = 3'd4,
    CMD_SUCC   = 3'd5
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    key_t       operand;
  } in_t;

  typedef struct packed {
    key_t result_value;
    logic found;
    logic dropped;
  } out_t;

  // Broadcast controls to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
    key_t operand;
  } ctl_t;

  // What a cell shows its neighbors and the result logic
  typedef struct packed {
    logic valid;
    logic ltv;
    logic eqv;
    key_t key;
  } cell_t;

endpackage

`default_nettype wire

// ===== design/order_statistic_sorted_set.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sorted set of distinct signed 32-bit keys with order-statistic queries.
// Input: a command (insert, remove, kth, count, predecessor, successor) and an
// operand are taken on a clock edge where start is high and busy is low.
// Output: one result per command on out_data, marked by out_valid for exactly
// one cycle; the receiver must take it then, it cannot hold results off.
// Sequence: the command is taken while the sequencer is idle; in the compare
// state every cell compares its key with the operand, and in the execute state
// the row shifts and the answer is registered. The result is shown in the
// following cycle, when the sequencer is idle again, so a new command may be
// taken while the result is shown; busy holds commands off during compare and
// execute.
// Keys sit in a row of CAPACITY cells in ascending order; an insert shifts
// cells at and above the slot one place up, a remove shifts them one down.
// Reset (synchronous, active low) empties the set and the sequencer; cell
// keys are left as they are and are ignored until written.

module order_statistic_sorted_set (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire osss_pkg::in_t in_data,
  output logic               out_valid,
  output osss_pkg::out_t     out_data
);

  localparam int CAP = osss_pkg::CAPACITY;

  osss_pkg::state_t state_r, state_nxt;
  osss_pkg::in_t    in_r;
  osss_pkg::out_t   out_r, out_nxt;
  logic             out_valid_r;
  logic             cmp_en, exec_en;

  osss_pkg::ctl_t   ctl;
  osss_pkg::cell_t  cells [CAP];
  osss_pkg::cell_t  tie_left, tie_right;

  logic [CAP-1:0] valid_vec, ltv_vec, eqv_vec, lev_vec;
  logic [CAP-1:0] bnd_vec, succ_vec, kth_vec;
  logic           present, full;

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      osss_pkg::ST_IDLE: if (start) state_nxt = osss_pkg::ST_CMP;
      osss_pkg::ST_CMP:  state_nxt = osss_pkg::ST_EXEC;
      osss_pkg::ST_EXEC: state_nxt = osss_pkg::ST_IDLE;
      default:           state_nxt = osss_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy    = 1'b1;
    cmp_en  = 1'b0;
    exec_en = 1'b0;
    case (state_r)
      osss_pkg::ST_IDLE: busy = 1'b0;
      osss_pkg::ST_CMP:  cmp_en = 1'b1;
      osss_pkg::ST_EXEC: exec_en = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // Flag vectors from the cell row
  for (genvar i = 0; i < CAP; i++) begin : g_vec
    assign valid_vec[i] = cells[i].valid;
    assign ltv_vec[i]   = cells[i].ltv;
    assign eqv_vec[i]   = cells[i].eqv;
    assign kth_vec[i]   = cells[i].valid &&
                          (in_r.operand == osss_pkg::KEY_W'(i + 1));
  end

  assign lev_vec  = ltv_vec | eqv_vec;
  // last key not above the operand
  assign bnd_vec  = lev_vec & ~(lev_vec >> 1);
  // first held key not below the operand
  assign succ_vec = valid_vec & ~ltv_vec & {ltv_vec[CAP-2:0], 1'b1};
  assign present  = |eqv_vec;
  assign full     = valid_vec[CAP-1];

  // Broadcast controls
  always_comb begin
    ctl.cmp_en  = cmp_en;
    ctl.ins_en  = exec_en && (in_r.cmd == osss_pkg::CMD_INSERT) && !present && !full;
    ctl.rem_en  = exec_en && (in_r.cmd == osss_pkg::CMD_REMOVE) && present;
    ctl.operand = in_r.operand;
  end

  // Row ends: cell 0 sees a left neighbor below the operand
  always_comb begin
    tie_left.valid  = 1'b1;
    tie_left.ltv    = 1'b1;
    tie_left.eqv    = 1'b0;
    tie_left.key    = in_r.operand;
    tie_right.valid = 1'b0;
    tie_right.ltv   = 1'b0;
    tie_right.eqv   = 1'b0;
    tie_right.key   = '0;
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    osss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .left_in  ((i == 0) ? tie_left : cells[(i == 0) ? 0 : i - 1]),
      .right_in ((i == CAP - 1) ? tie_right : cells[(i == CAP - 1) ? i : i + 1]),
      .cell_out (cells[i])
    );
  end

  // Result forming: one-hot selects OR-reduced over the row
  always_comb begin
    logic [CAP-1:0]       sel;
    osss_pkg::key_t       pick;
    logic [osss_pkg::CNT_W-1:0] cnt;
    sel  = '0;
    pick = '0;
    cnt  = '0;
    case (in_r.cmd)
      osss_pkg::CMD_KTH:  sel = kth_vec;
      osss_pkg::CMD_PRED: sel = bnd_vec;
      osss_pkg::CMD_SUCC: sel = succ_vec;
      default:            sel = '0;
    endcase
    for (int i = 0; i < CAP; i++) begin
      if (sel[i]) pick = pick | cells[i].key;
      if (bnd_vec[i]) cnt = cnt | osss_pkg::CNT_W'(i + 1);
    end
    out_nxt.result_value = '0;
    out_nxt.found        = 1'b0;
    out_nxt.dropped      = 1'b0;
    case (in_r.cmd)
      osss_pkg::CMD_INSERT: begin
        out_nxt.found   = !present && !full;
        out_nxt.dropped = !present && full;
      end
      osss_pkg::CMD_REMOVE: begin
        out_nxt.found = present;
      end
      osss_pkg::CMD_COUNT: begin
        out_nxt.result_value = osss_pkg::KEY_W'(cnt);
        out_nxt.found        = 1'b1;
      end
      osss_pkg::CMD_KTH, osss_pkg::CMD_PRED, osss_pkg::CMD_SUCC: begin
        out_nxt.found        = |sel;
        out_nxt.result_value = (|sel) ? pick : '1;
      end
      default: begin
        out_nxt.found = 1'b0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (start && !busy) in_r <= in_data;
    if (exec_en) out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= osss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= exec_en;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "order_statistic_sorted_set_assert.svh"

  `OSSS_ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `OSSS_ASSERT_NEXT(a_accept_cmp, clk, rst_n, start && !busy, state_r == osss_pkg::ST_CMP, "transfer did not start compare")
  `OSSS_ASSERT_IMPL(a_packed_row, clk, rst_n, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "hole in key row")
  `OSSS_ASSERT_IMPL(a_drop_full, clk, rst_n, out_valid && out_data.dropped, full, "drop without full row")

endmodule

`default_nettype wire

// ===== design/osss_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module osss_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire osss_pkg::ctl_t ctl,
  input  wire osss_pkg::cell_t left_in,
  input  wire osss_pkg::cell_t right_in,
  output osss_pkg::cell_t     cell_out
);

  osss_pkg::key_t key_r, key_nxt;
  logic valid_r, valid_nxt;
  logic ltv_r, ltv_nxt;
  logic eqv_r, eqv_nxt;

  // Compare phase latches flags; apply phase shifts toward or away from the slot
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    ltv_nxt   = ltv_r;
    eqv_nxt   = eqv_r;
    if (ctl.cmp_en) begin
      ltv_nxt = valid_r && (key_r < ctl.operand);
      eqv_nxt = valid_r && (key_r == ctl.operand);
    end
    if (ctl.ins_en && !ltv_r) begin
      // left neighbor below the operand marks the insertion slot; otherwise shift up
      key_nxt   = left_in.ltv ? ctl.operand : left_in.key;
      valid_nxt = left_in.ltv | left_in.valid;
    end
    if (ctl.rem_en && !ltv_r) begin
      key_nxt   = right_in.key;
      valid_nxt = right_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      ltv_r   <= 1'b0;
      eqv_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ltv_r   <= ltv_nxt;
      eqv_r   <= eqv_nxt;
    end
  end

  assign cell_out.valid = valid_r;
  assign cell_out.ltv   = ltv_r;
  assign cell_out.eqv   = eqv_r;
  assign cell_out.key   = key_r;

endmodule

`default_nettype wire
